[rtl/core/bnie_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnie_pkg
// Shared types, opcodes and register indexes of the batch-norm engine.
// ---------------------------------------------------------------------------
package bnie_pkg;

    localparam int LANES        = 8;
    localparam int DEF_CHANNELS = 32;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int QDEPTH       = 4;

    // word opcodes
    localparam logic [1:0] OP_FEAT = 2'd0;
    localparam logic [1:0] OP_MEAN = 2'd1;
    localparam logic [1:0] OP_VAR  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // register indexes
    localparam logic [2:0] REG_EPS  = 3'd0;
    localparam logic [2:0] REG_GAIN = 3'd1;
    localparam logic [2:0] REG_BIAS = 3'd2;
    localparam logic [2:0] REG_ROWS = 3'd3;
    localparam logic [2:0] REG_COLS = 3'd4;

    typedef logic signed [15:0] lane_t;

    typedef struct packed {
        logic [1:0]             op;
        logic [LANES-1:0][15:0] lanes;
    } cmd_t;

endpackage

[rtl/core/bnie_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnie_front
// Accepts input words, drops unknown opcodes and queues the rest for the
// back end.
// ---------------------------------------------------------------------------
module bnie_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bnie_pkg::cmd_t       in_cmd,
    output logic                 full,
    output logic                 cmd_valid,
    output bnie_pkg::cmd_t       cmd,
    input  logic                 cmd_ready
);
    import bnie_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          q_mem [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          enq, deq;

    // classify: only known opcodes enter the queue
    assign full      = (count_reg == CW'(QDEPTH));
    assign enq       = push && !full && (in_cmd.op != OP_NONE);
    assign cmd_valid = (count_reg != '0);
    assign deq       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/core/bnie_invroot.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnie_invroot
// Bit-serial inverse square root: floor sqrt, then rounded 2^48 / root.
// ---------------------------------------------------------------------------
module bnie_invroot (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bnie_pkg::lane_t      vin,
    input  logic [23:0]          eps,
    output logic                 done,
    output logic [31:0]          result
);
    import bnie_pkg::*;

    localparam logic [1:0] IR_IDLE = 2'd0;
    localparam logic [1:0] IR_SQRT = 2'd1;
    localparam logic [1:0] IR_DIV  = 2'd2;
    localparam logic [1:0] IR_FIN  = 2'd3;

    logic [1:0]  state_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [32:0] srem_reg;
    logic [31:0] root_reg;
    logic [48:0] dvd_reg;
    logic [31:0] drem_reg;
    logic [48:0] quo_reg;
    logic        zero_reg;

    logic [14:0] vpos;
    logic [39:0] s_val;
    logic [34:0] s_sh, s_trial, s_diff;
    logic        s_ge;
    logic [32:0] d_sh, d_diff;
    logic        d_ge;

    // radicand and square-root step
    assign vpos    = vin[15] ? 15'd0 : vin[14:0];
    assign s_val   = {1'b0, vpos, 24'd0} + {16'd0, eps};
    assign s_sh    = {srem_reg, rad_reg[63:62]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    assign s_ge    = (s_sh >= s_trial);
    assign s_diff  = s_sh - s_trial;

    // restoring divide step
    assign d_sh   = {drem_reg, dvd_reg[48]};
    assign d_ge   = (d_sh >= {1'b0, root_reg});
    assign d_diff = d_sh - {1'b0, root_reg};

    assign done   = (state_reg == IR_FIN);
    assign result = (zero_reg || (quo_reg[48:32] != '0)) ? 32'hFFFF_FFFF : quo_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                IR_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= IR_SQRT;
                        cnt_reg   <= 6'd31;
                    end
                end
                IR_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        if ({root_reg[30:0], s_ge} == '0)
                        begin
                            state_reg <= IR_FIN;
                        end
                        else
                        begin
                            state_reg <= IR_DIV;
                            cnt_reg   <= 6'd48;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                IR_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= IR_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                IR_FIN:
                begin
                    state_reg <= IR_IDLE;
                end
                default:
                begin
                    state_reg <= IR_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            IR_IDLE:
            begin
                rad_reg  <= {s_val, 24'd0};
                srem_reg <= '0;
                root_reg <= '0;
                zero_reg <= 1'b0;
            end
            IR_SQRT:
            begin
                rad_reg  <= {rad_reg[61:0], 2'b00};
                srem_reg <= s_ge ? s_diff[32:0] : s_sh[32:0];
                root_reg <= {root_reg[30:0], s_ge};
                zero_reg <= ({root_reg[30:0], s_ge} == '0);
                dvd_reg  <= {1'b1, 16'd0, 1'b0, root_reg[30:0]};
                drem_reg <= '0;
                quo_reg  <= '0;
            end
            IR_DIV:
            begin
                dvd_reg  <= {dvd_reg[47:0], 1'b0};
                drem_reg <= d_ge ? d_diff[31:0] : d_sh[31:0];
                quo_reg  <= {quo_reg[47:0], d_ge};
            end
            default:
            begin
                rad_reg <= rad_reg;
            end
        endcase
    end

endmodule

[rtl/core/bnie_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnie_back
// Executes queued words: table loads, inverse roots and normalization.
// ---------------------------------------------------------------------------
module bnie_back #(
    parameter int CHANNELS = bnie_pkg::DEF_CHANNELS,
    parameter int MAX_ROWS = bnie_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = bnie_pkg::DEF_MAX_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  bnie_pkg::cmd_t       cmd,
    output logic                 cmd_ready,
    input  logic [23:0]          eps,
    input  bnie_pkg::lane_t      gain,
    input  bnie_pkg::lane_t      bias,
    input  logic [6:0]           rows_cfg,
    input  logic [6:0]           cols_cfg,
    output logic                 out_valid,
    output bnie_pkg::lane_t      out_lanes [bnie_pkg::LANES],
    output logic                 out_last,
    input  logic                 out_pop
);
    import bnie_pkg::*;

    localparam int GROUPS = (CHANNELS + LANES - 1) / LANES;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RSW    = $clog2(MAX_ROWS + 1);
    localparam int CSW    = $clog2(MAX_COLS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_F1    = 3'd1;
    localparam logic [2:0] S_F2    = 3'd2;
    localparam logic [2:0] S_F3    = 3'd3;
    localparam logic [2:0] S_F4    = 3'd4;
    localparam logic [2:0] S_VREQ  = 3'd5;
    localparam logic [2:0] S_VWAIT = 3'd6;
    localparam logic [2:0] S_VWR   = 3'd7;

    logic [2:0]     state_reg;
    logic [GW-1:0]  mean_idx_reg, var_idx_reg, grp_reg;
    logic [RW-1:0]  row_reg;
    logic [CLW-1:0] col_reg;
    logic [2:0]     lane_idx_reg;
    logic           out_valid_reg;

    logic [LANES-1:0][15:0] mean_mem [GROUPS];
    logic [LANES-1:0][31:0] inv_mem  [GROUPS];
    logic [LANES-1:0][15:0] mean_q;
    logic [LANES-1:0][31:0] inv_q;
    logic [LANES-1:0][31:0] inv_row_reg;

    cmd_t                cmd_reg;
    logic signed [32:0]  p1_reg [LANES];
    logic signed [65:0]  p2_reg [LANES];
    logic signed [65:0]  t_reg  [LANES];
    lane_t               res    [LANES];
    lane_t               out_lanes_reg [LANES];
    logic                out_last_reg;

    logic                take, load_out;
    logic                ir_start, ir_done;
    logic [31:0]         ir_result;
    logic [RSW-1:0]      rows_use;
    logic [CSW-1:0]      cols_use;
    logic                col_end, row_end, grp_end;

    assign cmd_ready = (state_reg == S_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign load_out  = (state_reg == S_F4) && !out_valid_reg;
    assign ir_start  = (state_reg == S_VREQ);
    assign out_valid = out_valid_reg;
    assign out_lanes = out_lanes_reg;
    assign out_last  = out_last_reg;

    function automatic logic [GW-1:0] grp_inc(input logic [GW-1:0] g);
        grp_inc = (32'(g) + 1 >= GROUPS) ? '0 : g + 1'b1;
    endfunction

    // shared inverse-root unit
    bnie_invroot u_invroot (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ir_start),
        .vin    (lane_t'(cmd_reg.lanes[lane_idx_reg])),
        .eps    (eps),
        .done   (ir_done),
        .result (ir_result)
    );

    // tile size clamp and position flags
    always_comb
    begin
        if (rows_cfg == '0)
            rows_use = RSW'(1);
        else if (32'(rows_cfg) > MAX_ROWS)
            rows_use = RSW'(MAX_ROWS);
        else
            rows_use = RSW'(rows_cfg);
        if (cols_cfg == '0)
            cols_use = CSW'(1);
        else if (32'(cols_cfg) > MAX_COLS)
            cols_use = CSW'(MAX_COLS);
        else
            cols_use = CSW'(cols_cfg);
        col_end = (32'(col_reg) + 1 >= 32'(cols_use));
        row_end = (32'(row_reg) + 1 >= 32'(rows_use));
        grp_end = (32'(grp_reg) + 1 >= GROUPS);
    end

    // round half away from zero, saturate, blank lanes past the channel count
    always_comb
    begin
        logic        neg;
        logic [65:0] mag;
        logic [41:0] rnd;
        for (int k = 0; k < LANES; k++)
        begin
            neg = t_reg[k][65];
            mag = neg ? 66'(-t_reg[k]) : 66'(t_reg[k]);
            rnd = 42'((mag + 66'(24'h80_0000)) >> 24);
            if (32'(grp_reg) * LANES + k >= CHANNELS)
                res[k] = '0;
            else if (neg)
                res[k] = (rnd > 42'd32768) ? 16'sh8000 : lane_t'(-rnd[15:0]);
            else
                res[k] = (rnd > 42'd32767) ? 16'sh7FFF : lane_t'(rnd[15:0]);
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mean_idx_reg  <= '0;
            var_idx_reg   <= '0;
            grp_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            lane_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_pop)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        case (cmd.op)
                            OP_FEAT: state_reg <= S_F1;
                            OP_MEAN: mean_idx_reg <= grp_inc(mean_idx_reg);
                            OP_VAR:
                            begin
                                state_reg    <= S_VREQ;
                                lane_idx_reg <= '0;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_F1: state_reg <= S_F2;
                S_F2: state_reg <= S_F3;
                S_F3: state_reg <= S_F4;
                S_F4:
                begin
                    if (load_out)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        if (!col_end)
                            col_reg <= col_reg + 1'b1;
                        else
                        begin
                            col_reg <= '0;
                            if (!row_end)
                                row_reg <= row_reg + 1'b1;
                            else
                            begin
                                row_reg <= '0;
                                grp_reg <= grp_inc(grp_reg);
                            end
                        end
                    end
                end
                S_VREQ: state_reg <= S_VWAIT;
                S_VWAIT:
                begin
                    if (ir_done)
                    begin
                        if (lane_idx_reg == 3'(LANES - 1))
                            state_reg <= S_VWR;
                        else
                        begin
                            lane_idx_reg <= lane_idx_reg + 1'b1;
                            state_reg    <= S_VREQ;
                        end
                    end
                end
                S_VWR:
                begin
                    state_reg   <= S_IDLE;
                    var_idx_reg <= grp_inc(var_idx_reg);
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // table memories, read at the current channel group
    always_ff @(posedge clk)
    begin
        if (take && cmd.op == OP_MEAN)
            mean_mem[mean_idx_reg] <= cmd.lanes;
        if (state_reg == S_VWR)
            inv_mem[var_idx_reg] <= inv_row_reg;
        mean_q <= mean_mem[grp_reg];
        inv_q  <= inv_mem[grp_reg];
    end

    // datapath: subtract and gain, inverse root, bias, output word
    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd;
        if (state_reg == S_VWAIT && ir_done)
            inv_row_reg[lane_idx_reg] <= ir_result;
        for (int k = 0; k < LANES; k++)
        begin
            if (state_reg == S_F1)
                p1_reg[k] <= 33'(17'(signed'(cmd_reg.lanes[k])) - 17'(signed'(mean_q[k])))
                             * 33'(gain);
            if (state_reg == S_F2)
                p2_reg[k] <= 66'(p1_reg[k]) * 66'(signed'({1'b0, inv_q[k]}));
            if (state_reg == S_F3)
                t_reg[k] <= p2_reg[k] + (66'(bias) <<< 24);
            if (load_out)
                out_lanes_reg[k] <= res[k];
        end
        if (load_out)
            out_last_reg <= col_end && row_end && grp_end;
    end

endmodule

[rtl/core/batch_norm_inference_engine_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// batch_norm_inference_engine_top
// Batch-norm inference over 8-lane words with APB-style configuration.
// ---------------------------------------------------------------------------
// A feature word passes through the back end in order (group table read,
// x-mean times gain, times inverse root, bias add, round and saturate); the
// last step waits while the output register is full, and no new word is
// taken until the feature word is done. A mean word is written to its group
// table when taken. A variance word's eight lanes go one after the other
// through a single bit-serial unit, each lane taking a start step, a 32-step
// square root, a 49-step divide and a finish step (a lane whose root is zero
// skips the divide), and then the group is written. A 4-word queue lets input
// words be taken while the back end is busy; a finished word waits in the
// output register until popped. The tables are not cleared at reset.
module batch_norm_inference_engine_top #(
    parameter int CHANNELS = bnie_pkg::DEF_CHANNELS,
    parameter int MAX_ROWS = bnie_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = bnie_pkg::DEF_MAX_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           opcode,
    input  bnie_pkg::lane_t      lane0,
    input  bnie_pkg::lane_t      lane1,
    input  bnie_pkg::lane_t      lane2,
    input  bnie_pkg::lane_t      lane3,
    input  bnie_pkg::lane_t      lane4,
    input  bnie_pkg::lane_t      lane5,
    input  bnie_pkg::lane_t      lane6,
    input  bnie_pkg::lane_t      lane7,
    output logic                 empty,
    input  logic                 pop,
    output bnie_pkg::lane_t      out_lane0,
    output bnie_pkg::lane_t      out_lane1,
    output bnie_pkg::lane_t      out_lane2,
    output bnie_pkg::lane_t      out_lane3,
    output bnie_pkg::lane_t      out_lane4,
    output bnie_pkg::lane_t      out_lane5,
    output bnie_pkg::lane_t      out_lane6,
    output bnie_pkg::lane_t      out_lane7,
    output logic                 tile_last
);
    import bnie_pkg::*;

    logic [23:0] eps_reg;
    lane_t       gain_reg, bias_reg;
    logic [6:0]  rows_reg, cols_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    cmd_t        in_cmd, cmd;
    logic        cmd_valid, cmd_ready, out_valid;
    lane_t       out_lanes [LANES];

    // configuration registers
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= 24'd168;
            gain_reg <= 16'sd1;
            bias_reg <= 16'sd0;
            rows_reg <= 7'd64;
            cols_reg <= 7'd64;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_EPS:  eps_reg  <= pwdata[23:0];
                REG_GAIN: gain_reg <= lane_t'(pwdata[15:0]);
                REG_BIAS: bias_reg <= lane_t'(pwdata[15:0]);
                REG_ROWS: rows_reg <= pwdata[6:0];
                REG_COLS: cols_reg <= pwdata[6:0];
                default:  eps_reg  <= eps_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_EPS:  prdata = {8'd0, eps_reg};
            REG_GAIN: prdata = 32'(gain_reg);
            REG_BIAS: prdata = 32'(bias_reg);
            REG_ROWS: prdata = {25'd0, rows_reg};
            REG_COLS: prdata = {25'd0, cols_reg};
            default:  prdata = '0;
        endcase
    end

    // input word
    assign in_cmd.op    = opcode;
    assign in_cmd.lanes = {lane7, lane6, lane5, lane4, lane3, lane2, lane1, lane0};

    bnie_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_cmd    (in_cmd),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    bnie_back #(
        .CHANNELS (CHANNELS),
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .eps       (eps_reg),
        .gain      (gain_reg),
        .bias      (bias_reg),
        .rows_cfg  (rows_reg),
        .cols_cfg  (cols_reg),
        .out_valid (out_valid),
        .out_lanes (out_lanes),
        .out_last  (tile_last),
        .out_pop   (pop)
    );

    // result word
    assign empty     = !out_valid;
    assign out_lane0 = out_lanes[0];
    assign out_lane1 = out_lanes[1];
    assign out_lane2 = out_lanes[2];
    assign out_lane3 = out_lanes[3];
    assign out_lane4 = out_lanes[4];
    assign out_lane5 = out_lanes[5];
    assign out_lane6 = out_lanes[6];
    assign out_lane7 = out_lanes[7];

    // checks
    a_no_dropped_op: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |-> cmd.op != OP_NONE)
        else $error("unknown opcode reached back end");

    a_full_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cmd_valid)
        else $error("queue full without pending word");

    a_rows_written: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && reg_idx == REG_ROWS |=> rows_reg == $past(pwdata[6:0]))
        else $error("tile_rows write lost");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// batch-norm inference engine testbench
// Loads mean and variance tables, streams feature words through the block
// and checks every output word against a cycle-free predictor, lane by lane,
// across several register settings with random idling on both sides.
// ---------------------------------------------------------------------------
module testbench;

    import bnie_pkg::*;

    localparam int  NCH       = 32;
    localparam int  NGRP      = NCH / LANES;
    localparam int  TILE_MAX  = 64;
    localparam int  SETTLE    = 3500;
    localparam int  LIMIT     = 2000000;

    typedef struct {
        logic [1:0] op;
        lane_t      ln [LANES];
        bit         drain;
    } in_word_t;

    typedef struct {
        lane_t ln [LANES];
        logic  last;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push, full, empty, pop;
    logic [1:0]  opcode;
    lane_t       lane_d [LANES];
    lane_t       lane_q [LANES];
    logic        tile_last;

    batch_norm_inference_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .opcode(opcode),
        .lane0(lane_d[0]), .lane1(lane_d[1]), .lane2(lane_d[2]), .lane3(lane_d[3]),
        .lane4(lane_d[4]), .lane5(lane_d[5]), .lane6(lane_d[6]), .lane7(lane_d[7]),
        .empty(empty), .pop(pop),
        .out_lane0(lane_q[0]), .out_lane1(lane_q[1]), .out_lane2(lane_q[2]),
        .out_lane3(lane_q[3]), .out_lane4(lane_q[4]), .out_lane5(lane_q[5]),
        .out_lane6(lane_q[6]), .out_lane7(lane_q[7]),
        .tile_last(tile_last)
    );

    // predictor state
    logic [23:0] eps_r;
    lane_t       gain_r, bias_r;
    logic [6:0]  rows_r, cols_r;
    lane_t       mean_tab [NCH];
    logic [31:0] inv_tab  [NCH];
    int unsigned mean_idx, var_idx, grp_cnt, row_cnt, col_cnt;

    in_word_t  pending_words [$];
    out_word_t norm_expect   [$];
    in_word_t  cur;
    int        errors;
    int        results_seen;
    int        cycles;
    bit        idle_on;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // inverse root of variance plus epsilon, q8.24
    function automatic logic [31:0] inv_sqrt_q24(lane_t var_in);
        longint unsigned v, s, r, q;
        v = (var_in < 0) ? 0 : longint'(var_in);
        s = (v << 24) + longint'(eps_r);
        r = int_sqrt(s << 24);
        if (r == 0)
            return 32'hFFFF_FFFF;
        q = ((64'd1 << 48) + (r >> 1)) / r;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic lane_t bn_lane_value(lane_t x, int unsigned ch);
        logic signed [95:0] d, t, mag;
        if (ch >= NCH)
            return '0;
        d   = 96'(x) - 96'(mean_tab[ch]);
        t   = d * $signed({64'd0, inv_tab[ch]}) * 96'(gain_r) + 96'(bias_r) * 96'sd16777216;
        mag = (t < 0) ? -t : t;
        mag = (mag + 96'sd8388608) >>> 24;
        if (t < 0)
            return (mag > 32768) ? 16'sh8000 : lane_t'(-mag);
        return (mag > 32767) ? 16'sh7FFF : lane_t'(mag);
    endfunction

    // update tables or predict one output word
    task automatic predict_word(in_word_t w);
        out_word_t   o;
        int unsigned rows, cols;
        bit          ce, re, ge;
        rows = (rows_r < 1) ? 1 : ((rows_r > TILE_MAX) ? TILE_MAX : rows_r);
        cols = (cols_r < 1) ? 1 : ((cols_r > TILE_MAX) ? TILE_MAX : cols_r);
        if (w.op == OP_MEAN)
        begin
            for (int k = 0; k < LANES; k++)
                mean_tab[mean_idx * LANES + k] = w.ln[k];
            mean_idx = (mean_idx + 1 >= NGRP) ? 0 : mean_idx + 1;
        end
        else if (w.op == OP_VAR)
        begin
            for (int k = 0; k < LANES; k++)
                inv_tab[var_idx * LANES + k] = inv_sqrt_q24(w.ln[k]);
            var_idx = (var_idx + 1 >= NGRP) ? 0 : var_idx + 1;
        end
        else if (w.op == OP_FEAT)
        begin
            for (int k = 0; k < LANES; k++)
                o.ln[k] = bn_lane_value(w.ln[k], grp_cnt * LANES + k);
            ce = (col_cnt + 1 >= cols);
            re = (row_cnt + 1 >= rows);
            ge = (grp_cnt + 1 >= NGRP);
            o.last = ce && re && ge;
            norm_expect.push_back(o);
            if (!ce)
                col_cnt++;
            else
            begin
                col_cnt = 0;
                if (!re)
                    row_cnt++;
                else
                begin
                    row_cnt = 0;
                    grp_cnt = ge ? 0 : grp_cnt + 1;
                end
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch at word %0d: %s got %0d expected %0d", results_seen, what, got, want);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : drv
        int  gap;
        bit  nxt;
        if (!rst_n)
        begin
            push   <= 1'b0;
            opcode <= OP_NONE;
            for (int k = 0; k < LANES; k++)
                lane_d[k] <= '0;
            gap = 0;
        end
        else
        begin
            nxt = push;
            if (push && !full)
            begin
                predict_word(cur);
                nxt = 1'b0;
                gap = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (!nxt)
            begin
                if (gap > 0)
                    gap--;
                else if (pending_words.size() > 0 &&
                         (!pending_words[0].drain || norm_expect.size() == 0))
                begin
                    cur = pending_words.pop_front();
                    opcode <= cur.op;
                    for (int k = 0; k < LANES; k++)
                        lane_d[k] <= cur.ln[k];
                    nxt = 1'b1;
                end
            end
            push <= nxt;
        end
    end

    // output monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : mon
        int        gap;
        int        hold;
        bit        held;
        out_word_t e;
        if (!rst_n)
        begin
            pop <= 1'b0;
            gap = 0;
            hold = 0;
            held = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (norm_expect.size() == 0)
                begin
                    errors++;
                    $display("unexpected output word %0d", results_seen);
                end
                else
                begin
                    e = norm_expect.pop_front();
                    for (int k = 0; k < LANES; k++)
                        if (lane_q[k] !== e.ln[k])
                            report_mismatch($sformatf("out_lane%0d", k), lane_q[k], e.ln[k]);
                    if (tile_last !== e.last)
                        report_mismatch("tile_last", tile_last, e.last);
                end
                results_seen++;
                gap = idle_on ? $urandom_range(0, 7) : 0;
                // one long hold so the input queue backs up
                if (results_seen == 300 && !held)
                begin
                    hold = 1500;
                    held = 1;
                end
            end
            if (hold > 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("batch_norm_inference_engine_top verification failed");
            $finish;
        end
    end

    function automatic lane_t rand_lane();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return lane_t'($urandom_range(0, 64)) - 16'sd32;
            default: return lane_t'($urandom);
        endcase
    endfunction

    function automatic lane_t rand_var();
        case ($urandom_range(0, 7))
            0: return lane_t'($urandom) | 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return lane_t'($urandom_range(0, 15));
            default: return lane_t'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic in_word_t make_word(logic [1:0] op);
        in_word_t w;
        w.op = op;
        w.drain = 0;
        for (int k = 0; k < LANES; k++)
            w.ln[k] = (op == OP_VAR) ? rand_var() : rand_lane();
        return w;
    endfunction

    function automatic in_word_t fill_word(logic [1:0] op, lane_t v);
        in_word_t w;
        w.op = op;
        w.drain = 0;
        for (int k = 0; k < LANES; k++)
            w.ln[k] = v;
        return w;
    endfunction

    task automatic wait_idle();
        wait (pending_words.size() == 0 && !push && norm_expect.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write, setup then access cycle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EPS:  eps_r  = val[23:0];
            REG_GAIN: gain_r = val[15:0];
            REG_BIAS: bias_r = val[15:0];
            REG_ROWS: rows_r = val[6:0];
            REG_COLS: cols_r = val[6:0];
            default: ;
        endcase
    endtask

    task automatic queue_reload();
        for (int g = 0; g < NGRP; g++)
            pending_words.push_back(make_word(OP_MEAN));
        for (int g = 0; g < NGRP; g++)
            pending_words.push_back(make_word(OP_VAR));
    endtask

    task automatic queue_random(int n);
        int r;
        in_word_t w;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                queue_reload();
            else if (r < 5)
                w = make_word(OP_MEAN);
            else if (r < 7)
                w = make_word(OP_VAR);
            else if (r < 10)
                w = make_word(OP_NONE);
            else
                w = make_word(OP_FEAT);
            if (r >= 2)
            begin
                w.drain = ($urandom_range(0, 150) == 0);
                pending_words.push_back(w);
            end
        end
    endtask

    initial
    begin : stim
        in_word_t w;
        logic [31:0] settings [8][5];
        errors = 0;
        results_seen = 0;
        cycles = 0;
        idle_on = 1;
        eps_r = 24'd168;
        gain_r = 16'sd1;
        bias_r = '0;
        rows_r = 7'd64;
        cols_r = 7'd64;
        mean_idx = 0;
        var_idx = 0;
        grp_cnt = 0;
        row_cnt = 0;
        col_cnt = 0;
        for (int c = 0; c < NCH; c++)
        begin
            mean_tab[c] = '0;
            inv_tab[c] = '0;
        end
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed: full table load with extremes, then feature extremes
        pending_words.push_back(fill_word(OP_MEAN, 16'sh8000));
        pending_words.push_back(fill_word(OP_MEAN, 16'sh7FFF));
        pending_words.push_back(fill_word(OP_MEAN, 16'sd0));
        pending_words.push_back(make_word(OP_MEAN));
        pending_words.push_back(fill_word(OP_VAR, 16'sh8000));
        pending_words.push_back(fill_word(OP_VAR, 16'sd0));
        pending_words.push_back(fill_word(OP_VAR, 16'sh7FFF));
        pending_words.push_back(fill_word(OP_VAR, 16'sd1));
        for (int i = 0; i < 8; i++)
            pending_words.push_back(fill_word(OP_FEAT, (i % 2) ? 16'sh7FFF : 16'sh8000));
        pending_words.push_back(fill_word(OP_NONE, 16'sh7FFF));
        pending_words.push_back(fill_word(OP_FEAT, 16'sd0));
        // index wrap: a fifth mean word lands on group 0 again
        pending_words.push_back(fill_word(OP_MEAN, 16'sd5));
        pending_words.push_back(make_word(OP_FEAT));
        w = make_word(OP_FEAT);
        w.drain = 1;
        pending_words.push_back(w);
        pending_words.push_back(make_word(OP_FEAT));

        // eps, gain, bias, rows, cols per phase
        settings = '{
            '{32'd0,        32'h0000_7FFF, 32'h0000_8000, 32'd1,   32'd1},
            '{32'hFFFFFF,   32'h0000_8000, 32'h0000_7FFF, 32'd2,   32'd3},
            '{32'd168,      32'd1,         32'd0,         32'd0,   32'd127},
            '{32'd4096,     32'd3,         32'hFFFF_FFF0, 32'd3,   32'd2},
            '{32'h10000,    32'hFFFF_FFFF, 32'd100,       32'd64,  32'd64},
            '{32'd1,        32'd2,         32'd5,         32'd4,   32'd1},
            '{32'd100000,   32'd40,        32'hFFFF_8000, 32'd1,   32'd5},
            '{32'h800000,   32'd7,         32'd1000,      32'd2,   32'd2}
        };
        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            for (int r = 0; r < 5; r++)
                reg_write(r[2:0], settings[p][r]);
            // fresh variances so the new epsilon takes effect
            if (p % 2 == 0)
                queue_reload();
            idle_on = (p != 3);
            queue_random((p == 2 || p == 4) ? 60 : 200);
        end
        wait_idle();

        if (errors == 0)
            $display("batch_norm_inference_engine_top verification clean");
        else
            $display("batch_norm_inference_engine_top verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bnie_pkg.sv
rtl/core/bnie_front.sv
rtl/core/bnie_invroot.sv
rtl/core/bnie_back.sv
rtl/core/batch_norm_inference_engine_top.sv
tb/sv/testbench.sv
